[hdl/indexed_list_store_top_assert.svh]
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

[hdl/ils_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list store package
// Sizes, operation and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Signed width wide enough for a position and minus the length.
  localparam int RES_W  = ((CNT_W > 8) ? CNT_W : 8) + 2;

  localparam logic [2:0] OP_GET       = 3'd0;
  localparam logic [2:0] OP_INSERT    = 3'd1;
  localparam logic [2:0] OP_PUSH      = 3'd2;
  localparam logic [2:0] OP_POP       = 3'd3;
  localparam logic [2:0] OP_REMOVE    = 3'd4;
  localparam logic [2:0] OP_REMOVE_UN = 3'd5;
  localparam logic [2:0] OP_FIND      = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              exec;
    logic              ins_en;
    logic              rem_en;
    logic              unst_en;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [ELEM_W-1:0] value;
  } ils_ctrl_t;

endpackage

[hdl/ils_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one element, shifts with its neighbors and compares against a key.
// ----------------------------------------------------------------------------
module ils_cell (
  input  logic                      clk,
  input  ils_pkg::ils_ctrl_t        ctrl,
  input  logic [ils_pkg::CNT_W-1:0] slot,
  input  logic [ils_pkg::ELEM_W-1:0] prev_elem,
  input  logic [ils_pkg::ELEM_W-1:0] next_elem,
  input  logic [ils_pkg::ELEM_W-1:0] tail_elem,
  output logic [ils_pkg::ELEM_W-1:0] elem,
  output logic                      match,
  output logic [ils_pkg::ELEM_W-1:0] rd_pos,
  output logic [ils_pkg::ELEM_W-1:0] rd_last
);
  import ils_pkg::*;

  logic [CNT_W-1:0] slot_inc;

  assign slot_inc = slot + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      match <= (elem == ctrl.value) && (slot < ctrl.count);
    end
    if (ctrl.ins_en) begin
      if (slot == ctrl.pos) begin
        elem <= ctrl.value;
      end else if ((slot > ctrl.pos) && (slot <= ctrl.count)) begin
        elem <= prev_elem;
      end
    end else if (ctrl.rem_en) begin
      if ((slot >= ctrl.pos) && (slot_inc < ctrl.count)) begin
        elem <= next_elem;
      end
    end else if (ctrl.unst_en) begin
      // The hole is filled from the tail unless the hole is the tail.
      if ((slot == ctrl.pos) && (slot_inc < ctrl.count)) begin
        elem <= tail_elem;
      end
    end
  end

  assign rd_pos  = (slot == ctrl.pos) ? elem : '0;
  assign rd_last = (slot_inc == ctrl.count) ? elem : '0;

endmodule

[hdl/indexed_list_store_top.sv]
// ----------------------------------------------------------------------------
// Indexed list store top level
// Ordered list with positional get, insert, remove, push, pop, find and clear.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Fields
// command   in         start / busy         operation, position, value
// result    out        done (one cycle)     status, data, index, length
//
// An item runs after its accept edge through an execute cycle, in which
// every cell shifts, is written or compares in parallel, then a finish cycle
// with done high, in which busy is low and the next item may be accepted.
// No new item is taken while one executes. Reset is synchronous, active
// high, and empties the list at once; cells are not cleared, since only
// entries below the length are read. The receiver cannot stall.
//
`include "indexed_list_store_top_assert.svh"

module indexed_list_store_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        operation,
  input  logic signed [7:0] position,
  input  logic [31:0]       value,
  output logic              done,
  output logic [1:0]        status,
  output logic [31:0]       data,
  output logic [5:0]        index,
  output logic [6:0]        length
);
  import ils_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  // Item captured at the accept edge, with its position already resolved.
  logic [2:0]        op_q;
  logic [CNT_W-1:0]  pos_q;
  logic [ELEM_W-1:0] val_q;
  logic [CNT_W-1:0]  count;
  logic [1:0]        res_status;
  logic [ELEM_W-1:0] res_data;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state == S_EXEC);
  assign done   = (state == S_FINISH);

  // Python style position resolution against the current length.
  logic signed [RES_W-1:0] p_raw, len_s, p_res;
  logic [CNT_W-1:0]        pos_res;

  always_comb begin
    p_raw = RES_W'(position);
    len_s = $signed({{(RES_W - CNT_W){1'b0}}, count});
    if (p_raw > len_s) begin
      p_res = len_s;
    end else if (p_raw < -len_s) begin
      p_res = '0;
    end else begin
      p_res = p_raw;
    end
    if (p_res < 0) begin
      p_res = len_s + p_res;
    end
    pos_res = p_res[CNT_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_EXEC;
      S_EXEC:   state_next = S_FINISH;
      S_FINISH: state_next = accept ? S_EXEC : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      pos_q <= pos_res;
      val_q <= ELEM_W'(value);
    end
  end

  // Cell chain and the read buses gathered from it.
  logic [ELEM_W-1:0] cell_elem [DEPTH];
  logic [ELEM_W-1:0] cell_rd_pos [DEPTH];
  logic [ELEM_W-1:0] cell_rd_last [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  logic [ELEM_W-1:0] rd_pos, rd_last;
  ils_ctrl_t         ctrl;

  always_comb begin
    rd_pos  = '0;
    rd_last = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_pos  = rd_pos | cell_rd_pos[i];
      rd_last = rd_last | cell_rd_last[i];
    end
  end

  logic exec, is_full, pos_out;
  assign exec    = (state == S_EXEC);
  assign is_full = (count >= CNT_W'(DEPTH));
  assign pos_out = (pos_q >= count);

  always_comb begin
    ctrl.exec      = exec;
    ctrl.ins_en    = exec && ((op_q == OP_INSERT) || (op_q == OP_PUSH)) && !is_full;
    ctrl.rem_en    = exec && (op_q == OP_REMOVE) && !pos_out;
    ctrl.unst_en   = exec && (op_q == OP_REMOVE_UN) && !pos_out;
    // A push is an insert at the tail.
    ctrl.pos       = (op_q == OP_PUSH) ? count : pos_q;
    ctrl.count     = count;
    ctrl.value     = val_q;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ELEM_W-1:0] prev_e, next_e;
    if (k == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_lo
      assign prev_e = cell_elem[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_hi
      assign next_e = cell_elem[k+1];
    end
    ils_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .slot      (CNT_W'(k)),
      .prev_elem (prev_e),
      .next_elem (next_e),
      .tail_elem (rd_last),
      .elem      (cell_elem[k]),
      .match     (cell_match[k]),
      .rd_pos    (cell_rd_pos[k]),
      .rd_last   (cell_rd_last[k])
    );
  end

  // Length and the status of everything but find settle in the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec) begin
      case (op_q)
        OP_INSERT, OP_PUSH: if (!is_full) count <= count + CNT_W'(1);
        OP_POP:             if (count != '0) count <= count - CNT_W'(1);
        OP_REMOVE, OP_REMOVE_UN: if (!pos_out) count <= count - CNT_W'(1);
        OP_CLEAR:           count <= '0;
        default:            count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_status <= ST_OK;
      res_data   <= '0;
      case (op_q)
        OP_GET: begin
          if (pos_out) res_status <= ST_NOT_FOUND;
          else         res_data   <= rd_pos;
        end
        OP_INSERT, OP_PUSH: if (is_full) res_status <= ST_FULL;
        OP_POP: begin
          if (count == '0) res_status <= ST_EMPTY;
          else             res_data   <= rd_last;
        end
        OP_REMOVE, OP_REMOVE_UN: if (pos_out) res_status <= ST_NOT_FOUND;
        default: res_status <= ST_OK;
      endcase
    end
  end

  // First match wins: the lowest cell with its match flag set.
  logic             any_match;
  logic [IDX_W-1:0] match_idx;

  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        any_match = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  logic is_find;
  assign is_find = (op_q == OP_FIND);
  assign status  = is_find ? (any_match ? ST_OK : ST_NOT_FOUND) : res_status;
  assign data    = 32'(res_data);
  assign index   = (is_find && any_match) ? 6'(match_idx) : 6'd0;
  assign length  = 7'(count);

  `ILS_ASSERT_NOW(a_done_after_exec, done, $past(state == S_EXEC), "result without execute cycle")
  `ILS_ASSERT_NOW(a_count_bound, 1'b1, (count <= CNT_W'(DEPTH)), "length exceeds depth")
  `ILS_ASSERT_NEXT(a_busy_after_accept, accept, busy, "accepted item did not start")
  `ILS_ASSERT_NEXT(a_clear_empties, accept && (operation == OP_CLEAR), ##1 (done && (length == 7'd0)), "clear left elements")
  `ILS_ASSERT_NOW(a_full_status, done && (status == ST_FULL), (count == CNT_W'(DEPTH)), "full status below depth")

endmodule
